// ===== rtl/core/csfr_pkg.sv =====
// Shared constants, tables and helper functions for the clock strip frame renderer.
`timescale 1ns / 1ps

package csfr_pkg;

  // Strip and separator defaults.
  localparam int MASK_W         = 48;
  localparam int IDX_W          = $clog2(MASK_W);
  localparam int LED_COUNT_DEF  = 48;
  localparam int SEP_FIRST_DEF  = 26;
  localparam int SEP_SECOND_DEF = 11;

  // Digit segments: start pixel of each run and its longest run.
  // Order: seconds ones, seconds tens, minutes ones, minutes tens, hours ones, hours tens.
  localparam int SEG_COUNT   = 6;
  localparam int SEG_RUN_MAX = 9;
  localparam logic [5:0] SEG_START [SEG_COUNT] = '{6'd40, 6'd31, 6'd25, 6'd16, 6'd10, 6'd1};
  localparam logic [3:0] SEG_MAX   [SEG_COUNT] = '{4'd9, 4'd5, 4'd9, 4'd5, 4'd9, 4'd2};

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCHEDULE_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_HOUR          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_MINUTE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_HOUR         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_MINUTE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR_MODE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_SECONDS    = 3'd6;

  // Separator modes; any other code blinks.
  localparam logic [1:0] SEP_OFF   = 2'd0;
  localparam logic [1:0] SEP_ON    = 2'd1;
  localparam logic [1:0] SEP_BLINK = 2'd2;

  // Exact unsigned 32-bit division by 1000 through a reciprocal multiply.
  localparam int          MS_PER_S      = 1000;
  localparam logic [28:0] DIV1000_MUL   = 29'd274877907;
  localparam int          DIV1000_SHIFT = 38;
  localparam int          Q_W           = 23;
  localparam int          MS_LO_W       = 10;

  // Quotient by ten for a six-bit value (exact for every six-bit input).
  function automatic logic [2:0] div10(input logic [5:0] x);
    logic [13:0] p;
    p = {8'd0, x} * 14'd205;
    return p[13:11];
  endfunction

  // Remainder by ten for a six-bit value.
  function automatic logic [3:0] mod10(input logic [5:0] x);
    logic [5:0] t;
    logic [5:0] r;
    t = {3'd0, div10(x)} * 6'd10;
    r = x - t;
    return r[3:0];
  endfunction

  // One restoring remainder step: shift in one dividend bit, subtract if it fits.
  function automatic logic [5:0] mod_step(input logic [5:0] rem, input logic bit_in,
                                          input logic [5:0] div);
    logic [6:0] sh;
    sh = {rem, bit_in};
    if (sh >= {1'b0, div}) begin
      sh = sh - {1'b0, div};
    end
    return sh[5:0];
  endfunction

  // Minutes since midnight for an hour and minute pair.
  function automatic logic [10:0] clock_minutes(input logic [4:0] h, input logic [5:0] m);
    return ({6'd0, h} * 11'd60) + {5'd0, m};
  endfunction

endpackage

// ===== rtl/core/clock_strip_frame_render.sv =====
// Top level of the clock strip frame renderer: a five-stage frame pipeline.
`timescale 1ns / 1ps

// Renders one LED strip frame per time sample as a warm-white and a red pixel mask.
// Input channel: in_valid/in_stall carry hour, minute, second and now_ms; a word is
// taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall carry warm_mask, red_mask and display_active.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high, and writes to indexes past the register list are dropped. Write only when idle.
// Throughput is one word per cycle while the receiver does not stall. One stage holds
// the reciprocal multiply that splits now_ms into seconds and milliseconds, three stages
// sweep the remainder of that seconds count by the blink period (eight, eight and seven
// bits), and the output register makes the blink compare and the final masks.
// When the receiver stalls, the output holds its word and each stage that holds a
// word holds it too; empty stages keep filling, so bubbles close up and in_stall
// rises only once the whole pipeline is full.
// Synchronous reset empties the pipeline and restores the configuration defaults:
// schedule off, window 00:00 to 00:00, separator blinking with a one second period.
module clock_strip_frame_render
  import csfr_pkg::*;
#(
  parameter int LED_COUNT        = LED_COUNT_DEF,
  parameter int SEPARATOR_FIRST  = SEP_FIRST_DEF,
  parameter int SEPARATOR_SECOND = SEP_SECOND_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [4:0]            hour,
  input  logic [5:0]            minute,
  input  logic [5:0]            second,
  input  logic [31:0]           now_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MASK_W-1:0]     warm_mask,
  output logic [MASK_W-1:0]     red_mask,
  output logic                  display_active
);

  localparam int STEPS_A = 8;
  localparam int STEPS_B = 8;
  localparam int STEPS_C = Q_W - STEPS_A - STEPS_B;
  localparam int PROD_W  = 61;

  // Configuration registers.
  logic       schedule_enabled;
  logic [4:0] on_hour;
  logic [5:0] on_minute;
  logic [4:0] off_hour;
  logic [5:0] off_minute;
  logic [1:0] separator_mode;
  logic [5:0] blink_seconds;

  // Pipeline valid bits and stage readiness.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // Stage payloads.
  logic                 s1_allow;
  logic [3:0]           s1_dig [SEG_COUNT];
  logic [Q_W-1:0]       s1_q;
  logic [MS_LO_W-1:0]   s1_ms_lo;

  logic                 s2_allow;
  logic [MASK_W-1:0]    s2_warm;
  logic [5:0]           s2_rem;
  logic [STEPS_B+STEPS_C-1:0] s2_q_lo;
  logic [MS_LO_W-1:0]   s2_r;

  logic                 s3_allow;
  logic [MASK_W-1:0]    s3_warm;
  logic [5:0]           s3_rem;
  logic [STEPS_C-1:0]   s3_q_lo;
  logic [MS_LO_W-1:0]   s3_r;

  logic                 s4_allow;
  logic [MASK_W-1:0]    s4_warm;
  logic [5:0]           s4_rem;
  logic [MS_LO_W-1:0]   s4_r;

  // Stage logic results.
  logic                 allow_c;
  logic [3:0]           dig_c [SEG_COUNT];
  logic [PROD_W-1:0]    prod_c;
  logic [MASK_W-1:0]    warm_c;
  logic [5:0]           rem_a_c, rem_b_c, rem_c_c;
  logic [19:0]          qk_c;
  logic [MS_LO_W-1:0]   r_c;
  logic [14:0]          half_c;
  logic [15:0]          phase_c;
  logic                 lit_c;
  logic [MASK_W-1:0]    seps_c;

  // One-hot pixel bit, empty for pixels beyond the strip.
  function automatic logic [MASK_W-1:0] pixel_bit(input int idx);
    logic [MASK_W-1:0] m;
    m = '0;
    if (idx >= 0 && idx < LED_COUNT && idx < MASK_W) begin
      m[idx[IDX_W-1:0]] = 1'b1;
    end
    return m;
  endfunction

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      schedule_enabled <= 1'b0;
      on_hour          <= '0;
      on_minute        <= '0;
      off_hour         <= '0;
      off_minute       <= '0;
      separator_mode   <= SEP_BLINK;
      blink_seconds    <= 6'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCHEDULE_ENABLED: schedule_enabled <= cfg_data[0];
        CFG_ON_HOUR:          on_hour          <= cfg_data[4:0];
        CFG_ON_MINUTE:        on_minute        <= cfg_data;
        CFG_OFF_HOUR:         off_hour         <= cfg_data[4:0];
        CFG_OFF_MINUTE:       off_minute       <= cfg_data;
        CFG_SEPARATOR_MODE:   separator_mode   <= cfg_data[1:0];
        CFG_BLINK_SECONDS:    blink_seconds    <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its word moves on in the same cycle.
  assign rdy5     = !out_valid || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // Stage 1: schedule window, time digits and the seconds count of now_ms.
  always_comb begin
    logic [10:0] now_min;
    logic [10:0] on_min;
    logic [10:0] off_min;
    now_min = clock_minutes(hour, minute);
    on_min  = clock_minutes(on_hour, on_minute);
    off_min = clock_minutes(off_hour, off_minute);
    priority if (!schedule_enabled) begin
      allow_c = 1'b1;
    end else if (on_min == off_min) begin
      allow_c = 1'b0;
    end else if (on_min < off_min) begin
      allow_c = (now_min >= on_min) && (now_min < off_min);
    end else begin
      allow_c = (now_min >= on_min) || (now_min < off_min);
    end
    dig_c[0] = mod10(second);
    dig_c[1] = {1'b0, div10(second)};
    dig_c[2] = mod10(minute);
    dig_c[3] = {1'b0, div10(minute)};
    dig_c[4] = mod10({1'b0, hour});
    dig_c[5] = {1'b0, div10({1'b0, hour})};
    prod_c   = {29'd0, now_ms} * {32'd0, DIV1000_MUL};
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_allow <= allow_c;
      s1_dig   <= dig_c;
      s1_q     <= prod_c[DIV1000_SHIFT+Q_W-1:DIV1000_SHIFT];
      s1_ms_lo <= now_ms[MS_LO_W-1:0];
    end
  end

  // Stage 2: warm runs, millisecond remainder and the top remainder steps.
  always_comb begin
    logic [3:0] cnt;
    warm_c = '0;
    for (int s = 0; s < SEG_COUNT; s++) begin
      cnt = (s1_dig[s] < SEG_MAX[s]) ? s1_dig[s] : SEG_MAX[s];
      for (int i = 0; i < SEG_RUN_MAX; i++) begin
        if (i < int'(cnt)) begin
          warm_c = warm_c | pixel_bit(int'(SEG_START[s]) - i);
        end
      end
    end
    // The remainder below 1000 only needs the low bits of now_ms - 1000 * q.
    qk_c = {10'd0, s1_q[MS_LO_W-1:0]} * 20'(MS_PER_S);
    r_c  = s1_ms_lo - qk_c[MS_LO_W-1:0];
    rem_a_c = '0;
    for (int k = 0; k < STEPS_A; k++) begin
      rem_a_c = mod_step(rem_a_c, s1_q[Q_W-1-k], blink_seconds);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_allow <= s1_allow;
      s2_warm  <= warm_c;
      s2_rem   <= rem_a_c;
      s2_q_lo  <= s1_q[STEPS_B+STEPS_C-1:0];
      s2_r     <= r_c;
    end
  end

  // Stage 3: middle remainder steps.
  always_comb begin
    rem_b_c = s2_rem;
    for (int k = 0; k < STEPS_B; k++) begin
      rem_b_c = mod_step(rem_b_c, s2_q_lo[STEPS_B+STEPS_C-1-k], blink_seconds);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      s3_allow <= s2_allow;
      s3_warm  <= s2_warm;
      s3_rem   <= rem_b_c;
      s3_q_lo  <= s2_q_lo[STEPS_C-1:0];
      s3_r     <= s2_r;
    end
  end

  // Stage 4: last remainder steps give the whole seconds into the blink period.
  always_comb begin
    rem_c_c = s3_rem;
    for (int k = 0; k < STEPS_C; k++) begin
      rem_c_c = mod_step(rem_c_c, s3_q_lo[STEPS_C-1-k], blink_seconds);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      s4_allow <= s3_allow;
      s4_warm  <= s3_warm;
      s4_rem   <= rem_c_c;
      s4_r     <= s3_r;
    end
  end

  // Output stage: blink phase against half the period, separators and blanking.
  always_comb begin
    half_c  = {9'd0, blink_seconds} * 15'd500;
    phase_c = ({10'd0, s4_rem} * 16'(MS_PER_S)) + {6'd0, s4_r};
    unique case (separator_mode)
      SEP_OFF: lit_c = 1'b0;
      SEP_ON:  lit_c = 1'b1;
      default: lit_c = (blink_seconds == '0) || (phase_c >= {1'b0, half_c});
    endcase
    seps_c = pixel_bit(SEPARATOR_FIRST) | pixel_bit(SEPARATOR_SECOND);
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      warm_mask      <= s4_allow ? (s4_warm & ~seps_c) : '0;
      red_mask       <= (s4_allow && lit_c) ? seps_c : '0;
      display_active <= s4_allow;
    end
  end

endmodule

// ===== rtl/core/csfr_checker.sv =====
// Port-level checker for the clock strip frame renderer and its bind.
`timescale 1ns / 1ps

module csfr_checker
  import csfr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [MASK_W-1:0] warm_mask,
  input logic [MASK_W-1:0] red_mask,
  input logic              display_active
);

  // A stalled output word stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(warm_mask) && $stable(red_mask) &&
      $stable(display_active))
    else $error("stalled output word changed");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A frame outside the display window is fully dark.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !display_active |-> (warm_mask == '0) && (red_mask == '0))
    else $error("dark frame has lit pixels");

  // No pixel is warm white and red at once.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (warm_mask & red_mask) == '0)
    else $error("pixel both warm and red");

endmodule

bind clock_strip_frame_render csfr_checker u_csfr_checker (.*);
